@@ design/ssdg_pkg.sv @@
// Shared types, constants and the stencil lookup of the splat density grid.
// Used by ssdg_ctrl, ssdg_datapath and stencil_splat_density_grid.
`default_nettype none

package ssdg_pkg;

    localparam int DROP_COORD_W = 4;
    localparam int FOOT_W       = 2;
    localparam int EMPTY_W      = 9;
    localparam int PEAK_W       = 8;
    localparam int NUM_TAPS     = 13;
    localparam int TAP_IDX_W    = 4;
    localparam int TAP_OFS_W    = 3;

    // smallest footprint that includes a tap
    localparam logic [FOOT_W-1:0] FOOT_PLUS = 2'd1;
    localparam logic [FOOT_W-1:0] FOOT_DIAG = 2'd2;
    localparam logic [FOOT_W-1:0] FOOT_ARMS = 2'd3;

    localparam logic [TAP_IDX_W-1:0] LAST_TAP = TAP_IDX_W'(NUM_TAPS - 1);

    // two's complement offsets
    localparam logic [TAP_OFS_W-1:0] OFS_M2 = 3'b110;
    localparam logic [TAP_OFS_W-1:0] OFS_M1 = 3'b111;
    localparam logic [TAP_OFS_W-1:0] OFS_Z  = 3'b000;
    localparam logic [TAP_OFS_W-1:0] OFS_P1 = 3'b001;
    localparam logic [TAP_OFS_W-1:0] OFS_P2 = 3'b010;

    typedef struct packed {
        logic [DROP_COORD_W-1:0] drop_x;
        logic [DROP_COORD_W-1:0] drop_y;
        logic [FOOT_W-1:0]       footprint;
    } t_drop;

    typedef struct packed {
        logic [EMPTY_W-1:0] empty_cells;
        logic [PEAK_W-1:0]  peak_density;
    } t_grid_res;

    typedef struct packed {
        logic [TAP_OFS_W-1:0] dr;
        logic [TAP_OFS_W-1:0] dc;
        logic [FOOT_W-1:0]    lvl;
    } t_tap;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SPLAT,
        ST_DRAIN,
        ST_REPORT
    } t_state;

    typedef struct packed {
        logic clear_step;
        logic drop_load;
        logic tap_step;
        logic rpt_load;
    } t_dp_cmd;

    typedef struct packed {
        logic clear_last;
        logic tap_last;
        logic out_busy;
    } t_dp_sts;

    function automatic t_tap tap_lookup(input logic [TAP_IDX_W-1:0] idx);
        t_tap t;
        case (idx)
            4'd0:    t = '{dr: OFS_Z,  dc: OFS_Z,  lvl: FOOT_PLUS};
            4'd1:    t = '{dr: OFS_M1, dc: OFS_Z,  lvl: FOOT_PLUS};
            4'd2:    t = '{dr: OFS_P1, dc: OFS_Z,  lvl: FOOT_PLUS};
            4'd3:    t = '{dr: OFS_Z,  dc: OFS_M1, lvl: FOOT_PLUS};
            4'd4:    t = '{dr: OFS_Z,  dc: OFS_P1, lvl: FOOT_PLUS};
            4'd5:    t = '{dr: OFS_M1, dc: OFS_M1, lvl: FOOT_DIAG};
            4'd6:    t = '{dr: OFS_M1, dc: OFS_P1, lvl: FOOT_DIAG};
            4'd7:    t = '{dr: OFS_P1, dc: OFS_M1, lvl: FOOT_DIAG};
            4'd8:    t = '{dr: OFS_P1, dc: OFS_P1, lvl: FOOT_DIAG};
            4'd9:    t = '{dr: OFS_M2, dc: OFS_Z,  lvl: FOOT_ARMS};
            4'd10:   t = '{dr: OFS_P2, dc: OFS_Z,  lvl: FOOT_ARMS};
            4'd11:   t = '{dr: OFS_Z,  dc: OFS_M2, lvl: FOOT_ARMS};
            4'd12:   t = '{dr: OFS_Z,  dc: OFS_P2, lvl: FOOT_ARMS};
            default: t = '0; // sequencer stops at the last tap
        endcase
        return t;
    endfunction

endpackage

`default_nettype wire

@@ design/ssdg_ctrl.sv @@
// Sequencer of the splat density grid: clearing pass, tap walk, report.
// Depends on ssdg_pkg.
`default_nettype none

module ssdg_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    input  wire ssdg_pkg::t_dp_sts i_sts,
    output ssdg_pkg::t_dp_cmd     o_cmd
);
    import ssdg_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (i_sts.clear_last) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (i_in_valid) n_state = ST_SPLAT;
            end
            ST_SPLAT: begin
                if (i_sts.tap_last) n_state = ST_DRAIN;
            end
            ST_DRAIN: begin
                n_state = ST_REPORT;
            end
            ST_REPORT: begin
                if (!i_sts.out_busy) n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_CLEAR: begin
                o_cmd.clear_step = 1'b1;
            end
            ST_IDLE: begin
                o_in_ready      = 1'b1;
                o_cmd.drop_load = i_in_valid;
            end
            ST_SPLAT: begin
                o_cmd.tap_step = 1'b1;
            end
            ST_DRAIN: begin
                // last write-back lands this cycle
            end
            ST_REPORT: begin
                o_cmd.rpt_load = !i_sts.out_busy;
            end
            default: begin
            end
        endcase
    end

endmodule

`default_nettype wire

@@ design/ssdg_datapath.sv @@
// Grid memory with one-tap-per-cycle read-modify-write, running empty/peak
// counters and the result register. Depends on ssdg_pkg.
`default_nettype none

module ssdg_datapath #(
    parameter int GRID_SIZE  = 16,
    parameter int COUNT_BITS = 8
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire ssdg_pkg::t_dp_cmd   i_cmd,
    input  wire ssdg_pkg::t_drop     i_drop,
    input  wire logic                i_out_ready,
    output ssdg_pkg::t_dp_sts        o_sts,
    output logic                     o_out_valid,
    output ssdg_pkg::t_grid_res      o_out_res
);
    import ssdg_pkg::*;

    localparam int IW        = $clog2(GRID_SIZE);
    localparam int AW        = 2 * IW;
    localparam int MEM_DEPTH = 1 << AW;
    localparam int CELLS     = GRID_SIZE * GRID_SIZE;
    localparam int ZW        = $clog2(CELLS + 1);
    // signed coordinate: holds -2 and the largest row or grid bound
    localparam int CW        = $clog2(GRID_SIZE + 18) + 1;

    logic [COUNT_BITS-1:0] r_mem [MEM_DEPTH];
    logic [COUNT_BITS-1:0] r_rd_data;

    t_drop                 r_drop;
    logic [TAP_IDX_W-1:0]  r_tap;
    logic [AW-1:0]         r_clr_addr;
    logic                  r_wr_pend;
    logic [AW-1:0]         r_wr_addr;
    logic [ZW-1:0]         r_zero;
    logic [COUNT_BITS-1:0] r_peak;
    logic                  r_out_valid;
    t_grid_res             r_out;

    logic                  n_wr_pend;
    t_tap                  w_tap;
    logic signed [CW-1:0]  w_row;
    logic signed [CW-1:0]  w_col;
    logic signed [CW-1:0]  w_bound;
    logic                  w_in_grid;
    logic [AW-1:0]         w_tap_addr;
    logic                  w_sat;
    logic [COUNT_BITS-1:0] w_inc;
    logic                  w_bump;
    logic                  w_we;
    logic [AW-1:0]         w_waddr;
    logic [COUNT_BITS-1:0] w_wdata;

    // stencil cell of the current tap
    always_comb begin
        w_tap      = tap_lookup(r_tap);
        w_row      = $signed(CW'(r_drop.drop_x)) + CW'($signed(w_tap.dr));
        w_col      = $signed(CW'(r_drop.drop_y)) + CW'($signed(w_tap.dc));
        w_bound    = $signed(CW'(GRID_SIZE));
        w_in_grid  = (w_row >= 0) && (w_col >= 0) && (w_row < w_bound) && (w_col < w_bound);
        w_tap_addr = {w_row[IW-1:0], w_col[IW-1:0]};
        n_wr_pend  = i_cmd.tap_step && w_in_grid && (r_drop.footprint >= w_tap.lvl);
    end

    // write-back of the previous tap, or the clearing pass
    always_comb begin
        w_sat  = &r_rd_data;
        w_inc  = r_rd_data + 1'b1;
        w_bump = r_wr_pend && !w_sat;
        if (i_cmd.clear_step) begin
            w_we    = 1'b1;
            w_waddr = r_clr_addr;
            w_wdata = '0;
        end else begin
            w_we    = w_bump;
            w_waddr = r_wr_addr;
            w_wdata = w_inc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) r_mem[w_waddr] <= w_wdata;
        r_rd_data <= r_mem[w_tap_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.drop_load) r_drop <= i_drop;
        r_wr_addr <= w_tap_addr;
        if (i_cmd.rpt_load) begin
            r_out.empty_cells  <= EMPTY_W'(r_zero);
            r_out.peak_density <= PEAK_W'(r_peak);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tap       <= '0;
            r_clr_addr  <= '0;
            r_wr_pend   <= 1'b0;
            r_zero      <= ZW'(CELLS);
            r_peak      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_wr_pend <= n_wr_pend;
            if (i_cmd.clear_step) r_clr_addr <= r_clr_addr + 1'b1;
            if (i_cmd.drop_load) begin
                r_tap <= '0;
            end else if (i_cmd.tap_step) begin
                r_tap <= r_tap + 1'b1;
            end
            if (w_bump) begin
                if ((r_rd_data == '0) && (r_zero != '0)) r_zero <= r_zero - 1'b1;
                if (w_inc > r_peak) r_peak <= w_inc;
            end
            if (i_cmd.rpt_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_sts.clear_last = &r_clr_addr;
    assign o_sts.tap_last   = (r_tap == LAST_TAP);
    assign o_sts.out_busy   = r_out_valid && !i_out_ready;
    assign o_out_valid      = r_out_valid;
    assign o_out_res        = r_out;

endmodule

`default_nettype wire

@@ design/stencil_splat_density_grid.sv @@
// Splat density grid: each accepted drop is walked over 13 taps, one read-modify-write
// each on the grid memory's single write port, then a write-back drain and a report load.
// One drop at a time: no new drop is accepted until the previous one has been reported;
// report waits while the previous word is still pending, holding the input.
// Synchronous active-low reset, then a clearing pass over all 2^(2*ceil(log2 GRID_SIZE))
// memory words (256 at default size) with o_in_ready low.
`default_nettype none

module stencil_splat_density_grid #(
    parameter int GRID_SIZE  = 16,
    parameter int COUNT_BITS = 8
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire ssdg_pkg::t_drop      i_in_drop,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output ssdg_pkg::t_grid_res       o_out_res
);
    import ssdg_pkg::*;

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    ssdg_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    ssdg_datapath #(
        .GRID_SIZE  (GRID_SIZE),
        .COUNT_BITS (COUNT_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_drop      (i_in_drop),
        .i_out_ready (i_out_ready),
        .o_sts       (w_sts),
        .o_out_valid (o_out_valid),
        .o_out_res   (o_out_res)
    );

    // one drop in flight: no second accept right after the first
    a_one_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input accepted while a drop is in flight");

    // a pending result word is never overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.rpt_load |-> !(o_out_valid && !i_out_ready))
        else $error("result register overwritten");

    // clearing pass and tap walk never share the memory write port
    a_port_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.clear_step |-> !(w_cmd.tap_step || w_cmd.drop_load || o_in_ready))
        else $error("clearing pass overlaps drop work");

endmodule

`default_nettype wire

@@ sim/stencil_splat_density_grid_tb.sv @@
// Self-checking bench for stencil_splat_density_grid: drops go in, each result word is
// checked against a cycle-free grid tracker kept in the bench.
// Depends on ssdg_pkg and the stencil_splat_density_grid RTL.
`default_nettype none

module stencil_splat_density_grid_tb;
    import ssdg_pkg::*;

    localparam int GRID_N      = 16;
    localparam int CELL_MAX    = 255;
    localparam int HOLD_CYCLES = 300;
    localparam int END_WAIT    = 40;
    localparam int CYCLE_LIMIT = 400000;

    localparam logic [FOOT_W-1:0] FOOT_NONE = 2'd0;

    // stencil: row step, column step, smallest footprint that covers the cell
    localparam int ROW_STEP [NUM_TAPS] = '{0, -1, 1, 0, 0, -1, -1, 1, 1, -2, 2, 0, 0};
    localparam int COL_STEP [NUM_TAPS] = '{0, 0, 0, -1, 1, -1, 1, -1, 1, 0, 0, -2, 2};
    localparam logic [FOOT_W-1:0] TAP_LEVEL [NUM_TAPS] = '{
        FOOT_PLUS, FOOT_PLUS, FOOT_PLUS, FOOT_PLUS, FOOT_PLUS,
        FOOT_DIAG, FOOT_DIAG, FOOT_DIAG, FOOT_DIAG,
        FOOT_ARMS, FOOT_ARMS, FOOT_ARMS, FOOT_ARMS};

    class splat_tracker;
        int        cell_count [GRID_N][GRID_N];
        int        empty_total;
        int        peak;
        t_grid_res pending_stats [$];
        int        errors;

        function new();
            foreach (cell_count[r, c]) cell_count[r][c] = 0;
            empty_total = GRID_N * GRID_N;
            peak        = 0;
            errors      = 0;
        endfunction

        function void apply_drop(t_drop d);
            int r;
            int c;
            t_grid_res stats;
            for (int k = 0; k < NUM_TAPS; k++) begin
                if (d.footprint >= TAP_LEVEL[k]) begin
                    r = int'(d.drop_x) + ROW_STEP[k];
                    c = int'(d.drop_y) + COL_STEP[k];
                    if (r >= 0 && c >= 0 && r < GRID_N && c < GRID_N &&
                        cell_count[r][c] < CELL_MAX) begin
                        if (cell_count[r][c] == 0) empty_total--;
                        cell_count[r][c]++;
                        if (cell_count[r][c] > peak) peak = cell_count[r][c];
                    end
                end
            end
            stats.empty_cells  = EMPTY_W'(empty_total);
            stats.peak_density = PEAK_W'(peak);
            pending_stats.push_back(stats);
        endfunction

        function void match_stats(t_grid_res got);
            t_grid_res want;
            if (pending_stats.size() == 0) begin
                $display("%0t: unexpected result word, expected none, actual empty %0d peak %0d",
                         $time, got.empty_cells, got.peak_density);
                errors++;
                return;
            end
            want = pending_stats.pop_front();
            if (got.empty_cells !== want.empty_cells) begin
                $display("%0t: empty_cells mismatch, expected %0d actual %0d",
                         $time, want.empty_cells, got.empty_cells);
                errors++;
            end
            if (got.peak_density !== want.peak_density) begin
                $display("%0t: peak_density mismatch, expected %0d actual %0d",
                         $time, want.peak_density, got.peak_density);
                errors++;
            end
        endfunction

        function int outstanding();
            return pending_stats.size();
        endfunction
    endclass

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_in_valid = 1'b0;
    logic      o_in_ready;
    t_drop     i_in_drop = '0;
    logic      o_out_valid;
    logic      i_out_ready = 1'b0;
    t_grid_res o_out_res;

    splat_tracker tracker = new();
    bit           hold_off_req = 1'b0;
    bit           quiet_tail = 1'b0;
    int           cycle_count = 0;

    stencil_splat_density_grid u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_drop   (i_in_drop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_res   (o_out_res)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("stencil_splat_density_grid test failed");
            $finish;
        end
    end

    // sample both handshakes on the pre-edge values
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) tracker.match_stats(o_out_res);
            if (i_in_valid && o_in_ready) tracker.apply_drop(i_in_drop);
        end
    end

    // result side: random stall bursts, long runs, one long hold-off on request
    initial begin
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_off_req) begin
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_off_req = 1'b0;
            end else if (!quiet_tail && $urandom_range(0, 3) == 0) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge i_clk);
            end else begin
                i_out_ready <= 1'b1;
                repeat ($urandom_range(1, ($urandom_range(0, 4) == 0) ? 60 : 12))
                    @(posedge i_clk);
            end
        end
    end

    // Called at a rising edge; returns at the edge where the word is taken.
    // Valid stays high afterwards so back-to-back drops need no extra edge.
    task automatic offer_drop(input t_drop d);
        int gap;
        gap = 0;
        if (!quiet_tail && $urandom_range(0, 2) == 0) gap = $urandom_range(1, 7);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_drop  <= d;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic drop_at(input int x, input int y, input logic [FOOT_W-1:0] fp);
        t_drop d;
        d.drop_x    = DROP_COORD_W'(x);
        d.drop_y    = DROP_COORD_W'(y);
        d.footprint = fp;
        offer_drop(d);
    endtask

    task automatic random_drops(input int n);
        for (int i = 0; i < n; i++)
            drop_at($urandom_range(0, GRID_N - 1), $urandom_range(0, GRID_N - 1),
                    FOOT_W'($urandom_range(0, 3)));
    endtask

    // always advances at least one edge, so valid never drops and rises in one step
    task automatic drain_results();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (tracker.outstanding() != 0);
    endtask

    initial begin
        int bx;
        int by;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // corners, edges (off-grid arms), every footprint
        drop_at(0, 0, FOOT_NONE);
        drop_at(0, 0, FOOT_ARMS);
        drop_at(15, 15, FOOT_ARMS);
        drop_at(0, 15, FOOT_ARMS);
        drop_at(15, 0, FOOT_ARMS);
        drop_at(1, 1, FOOT_ARMS);
        drop_at(14, 14, FOOT_ARMS);
        drop_at(1, 14, FOOT_ARMS);
        drop_at(14, 1, FOOT_ARMS);
        drop_at(0, 7, FOOT_PLUS);
        drop_at(15, 8, FOOT_PLUS);
        drop_at(7, 0, FOOT_PLUS);
        drop_at(8, 15, FOOT_PLUS);
        drop_at(0, 0, FOOT_DIAG);
        drop_at(15, 15, FOOT_DIAG);
        drop_at(8, 15, FOOT_DIAG);
        drop_at(7, 7, FOOT_ARMS);
        drop_at(8, 8, FOOT_ARMS);
        drop_at(15, 15, FOOT_NONE);
        drop_at(5, 10, FOOT_DIAG);
        drop_at(10, 5, FOOT_PLUS);
        drain_results();

        random_drops(350);

        // result side stalls for a long stretch while drops keep coming
        hold_off_req = 1'b1;
        random_drops(30);

        // hot spot: centres packed in a 3x3 window so the middle cells saturate
        bx = $urandom_range(0, GRID_N - 3);
        by = $urandom_range(0, GRID_N - 3);
        for (int i = 0; i < 450; i++)
            drop_at(bx + $urandom_range(0, 2), by + $urandom_range(0, 2),
                    FOOT_W'($urandom_range(1, 3)));
        drain_results();

        random_drops(350);

        quiet_tail = 1'b1;
        random_drops(170);

        i_in_valid <= 1'b0;
        for (int i = 0; i < 5000 && tracker.outstanding() != 0; i++) @(posedge i_clk);
        repeat (END_WAIT) @(posedge i_clk);
        if (tracker.outstanding() != 0) begin
            $display("%0t: %0d results never arrived, expected %0d actual 0",
                     $time, tracker.outstanding(), tracker.outstanding());
            tracker.errors++;
        end
        if (tracker.errors == 0) begin
            $display("stencil_splat_density_grid test passed");
        end else begin
            $display("stencil_splat_density_grid test failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
